/* sv/evz_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ZXZ Euler rotation core.
// No dependencies; every other file refers to this package by scoped names.
package evz_pkg;

  // fixed-point formats
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int MAT_W          = TRIG_W + 1;
  localparam int COORD_W        = 32;
  localparam int ANGLE_W        = 16;

  // angle units: 1/64 degree
  localparam int ANG_TURN    = 23040;
  localparam int ANG_HALF    = 11520;
  localparam int ANG_QUARTER = 5760;
  localparam int ANG_EIGHTH  = 2880;

  // radian argument x = round(g * pi / ANG_HALF) in Q30, pi in Q48
  localparam logic [63:0] PI_Q48 = 64'h3_243F_6A88_85A3;
  localparam int          X_ODD  = 45;
  localparam int          X_SH   = 26;
  // X_ODD << X_SH equals ANG_HALF << 18
  localparam logic [63:0] X_DIV  = 64'(X_ODD) << X_SH;
  localparam logic [18:0] PI_QUO = 19'(PI_Q48 / X_DIV);
  localparam logic [31:0] PI_REM = 32'(PI_Q48 % X_DIV);
  localparam logic [31:0] X_RND  = 32'(64'(ANG_HALF) << 17);

  // pipeline depths
  localparam int LANE_LAT = 25;
  localparam int MRG_LAT  = 5;
  localparam int PIPE_LAT = LANE_LAT + MRG_LAT;
  localparam int PT_LAT   = LANE_LAT + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    trig_t sn;
    trig_t cs;
  } trig_pair_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // series divisors for sine and cosine terms
  function automatic int sin_div(input int k);
    return (2 * k) * (2 * k + 1);
  endfunction

  function automatic int cos_div(input int k);
    return (2 * k - 1) * (2 * k);
  endfunction

  // unsigned Q30 product, rounded
  function automatic logic [30:0] mul30(input logic [30:0] t, input logic [29:0] m);
    logic [61:0] p;
    p = 62'(t) * 62'(m) + (62'(1) << 29);
    return p[60:30];
  endfunction

endpackage

/* sv/evz_in_if.sv */
`timescale 1ns / 1ps
// Input request channel: point and three Euler angles with valid/ready.
// Depends on evz_pkg for field types.
interface evz_in_if;
  logic            valid;
  logic            ready;
  evz_pkg::coord_t px;
  evz_pkg::coord_t py;
  evz_pkg::coord_t pz;
  evz_pkg::angle_t angle_phi;
  evz_pkg::angle_t angle_theta;
  evz_pkg::angle_t angle_psi;

  modport source (output valid, px, py, pz, angle_phi, angle_theta, angle_psi,
                  input ready);
  modport sink (input valid, px, py, pz, angle_phi, angle_theta, angle_psi,
                output ready);
endinterface

/* sv/evz_out_if.sv */
`timescale 1ns / 1ps
// Result request channel: rotated point with valid/ready.
// Depends on evz_pkg for field types.
interface evz_out_if;
  logic            valid;
  logic            ready;
  evz_pkg::coord_t rx;
  evz_pkg::coord_t ry;
  evz_pkg::coord_t rz;

  modport source (output valid, rx, ry, rz, input ready);
  modport sink (input valid, rx, ry, rz, output ready);
endinterface

/* sv/evz_trig_lane.sv */
`timescale 1ns / 1ps
// One trig lane: sine and cosine of an angle by octant reduction and a
// pipelined Taylor series. Depends on evz_pkg.
module evz_trig_lane (
  input  logic                clk,
  input  logic                en,
  input  evz_pkg::angle_t     angle,
  output evz_pkg::trig_pair_t trig
);

  localparam int SH = 30 - evz_pkg::TRIG_FRAC_BITS;
  localparam int UW = evz_pkg::TRIG_FRAC_BITS + 1;
  localparam logic signed [16:0] TURN_S  = 17'(evz_pkg::ANG_TURN);
  localparam logic [14:0]        R_Q1    = 15'(evz_pkg::ANG_QUARTER);
  localparam logic [14:0]        R_Q2    = 15'(2 * evz_pkg::ANG_QUARTER);
  localparam logic [14:0]        R_Q3    = 15'(3 * evz_pkg::ANG_QUARTER);
  localparam logic [12:0]        F_QUART = 13'(evz_pkg::ANG_QUARTER);
  localparam logic [12:0]        F_EIGHT = 13'(evz_pkg::ANG_EIGHTH);
  localparam logic [17:0]        W_ODD   = 18'(evz_pkg::X_ODD);
  localparam logic [12:0]        W_RCP   = 13'((64'd1 << 18) / evz_pkg::X_ODD);
  localparam logic [30:0]        ONE_Q30 = 31'(64'd1 << 30);

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    quad_t quad;
    logic  swap;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [43:0] p1;
    logic [29:0] gq;
  } xa_t;

  typedef struct packed {
    meta_t       meta;
    logic [17:0] w;
    logic [30:0] pw;
    logic [29:0] gq;
  } xb_t;

  typedef struct packed {
    meta_t       meta;
    logic [29:0] x;
  } xc_t;

  typedef struct packed {
    logic [30:0]        ts;
    logic [30:0]        tc;
    logic signed [31:0] ss;
    logic signed [31:0] cc;
    logic [29:0]        x2;
    meta_t              meta;
  } step_t;

  typedef struct packed {
    step_t       st;
    logic [30:0] vs;
    logic [30:0] vc;
  } mul_t;

  typedef struct packed {
    step_t       st;
    logic [30:0] vs;
    logic [30:0] vc;
    logic [60:0] ps;
    logic [60:0] pc;
  } rcp_t;

  function automatic logic [UW-1:0] to_trig(input logic signed [31:0] v);
    logic [30:0] c;
    logic [30:0] sum;
    if (v < 0) begin
      c = '0;
    end else if (v > $signed({1'b0, ONE_Q30})) begin
      c = ONE_Q30;
    end else begin
      c = v[30:0];
    end
    sum = c + (31'(1) << (SH - 1));
    return UW'(sum >> SH);
  endfunction

  logic [14:0] r_r, r_nxt;
  meta_t       m2_r, m2_nxt;
  logic [11:0] g_r, g_nxt;
  xa_t         xa_r, xa_nxt;
  xb_t         xb_r, xb_nxt;
  xc_t         xc_r, xc_nxt;
  step_t       st_r [0:6];
  step_t       st_nxt [0:6];
  mul_t        mul_r [1:6];
  mul_t        mul_nxt [1:6];
  rcp_t        rcp_r [1:6];
  rcp_t        rcp_nxt [1:6];
  evz_pkg::trig_pair_t trig_r, trig_nxt;

  // wrap the angle into one turn
  always_comb begin
    logic signed [16:0] a;
    a = {angle[15], angle};
    if (a < 0) begin
      a = a + TURN_S;
      if (a < 0) begin
        a = a + TURN_S;
      end
    end else if (a >= TURN_S) begin
      a = a - TURN_S;
    end
    r_nxt = a[14:0];
  end

  // quadrant, in-quadrant offset and octant fold
  always_comb begin
    logic [14:0] f;
    if (r_r >= R_Q3) begin
      m2_nxt.quad = QUAD_3;
      f = r_r - R_Q3;
    end else if (r_r >= R_Q2) begin
      m2_nxt.quad = QUAD_2;
      f = r_r - R_Q2;
    end else if (r_r >= R_Q1) begin
      m2_nxt.quad = QUAD_1;
      f = r_r - R_Q1;
    end else begin
      m2_nxt.quad = QUAD_0;
      f = r_r;
    end
    m2_nxt.swap = (f[12:0] > F_EIGHT);
    g_nxt = m2_nxt.swap ? 12'(F_QUART - f[12:0]) : f[11:0];
  end

  // radian argument: integer part of the quotient and the remainder product
  always_comb begin
    xa_nxt.meta = m2_r;
    xa_nxt.p1   = 44'(g_r) * 44'(evz_pkg::PI_REM) + 44'(evz_pkg::X_RND);
    xa_nxt.gq   = 30'(31'(g_r) * 31'(evz_pkg::PI_QUO));
  end

  // remainder quotient by the odd factor: reciprocal product
  always_comb begin
    xb_nxt.meta = xa_r.meta;
    xb_nxt.w    = xa_r.p1[43:26];
    xb_nxt.pw   = 31'(xb_nxt.w) * 31'(W_RCP);
    xb_nxt.gq   = xa_r.gq;
  end

  // reciprocal correction and final argument
  always_comb begin
    logic [12:0] q0;
    logic [17:0] rem;
    logic [12:0] q;
    q0  = xb_r.pw[30:18];
    rem = xb_r.w - 18'(18'(q0) * W_ODD);
    q   = q0 + 13'(rem >= W_ODD);
    xc_nxt.meta = xb_r.meta;
    xc_nxt.x    = xb_r.gq + 30'(q);
  end

  // series start: x, x squared, cosine one
  always_comb begin
    logic [30:0] sq;
    sq = evz_pkg::mul30({1'b0, xc_r.x}, xc_r.x);
    st_nxt[0].ts   = {1'b0, xc_r.x};
    st_nxt[0].tc   = ONE_Q30;
    st_nxt[0].ss   = $signed({2'b00, xc_r.x});
    st_nxt[0].cc   = $signed({1'b0, ONE_Q30});
    st_nxt[0].x2   = sq[29:0];
    st_nxt[0].meta = xc_r.meta;
  end

  // series terms, three stages each
  for (genvar k = 1; k <= 6; k++) begin : g_step
    localparam int          DS  = evz_pkg::sin_div(k);
    localparam int          DC  = evz_pkg::cos_div(k);
    localparam logic [29:0] MS  = 30'((64'd1 << 30) / DS);
    localparam logic [29:0] MC  = 30'((64'd1 << 30) / DC);
    localparam logic [30:0] DSV = 31'(DS);
    localparam logic [30:0] DCV = 31'(DC);

    // term times x squared
    always_comb begin
      mul_nxt[k].st = st_r[k-1];
      mul_nxt[k].vs = evz_pkg::mul30(st_r[k-1].ts, st_r[k-1].x2);
      mul_nxt[k].vc = evz_pkg::mul30(st_r[k-1].tc, st_r[k-1].x2);
    end

    // reciprocal products for the divisions
    always_comb begin
      rcp_nxt[k].st = mul_r[k].st;
      rcp_nxt[k].vs = mul_r[k].vs;
      rcp_nxt[k].vc = mul_r[k].vc;
      rcp_nxt[k].ps = 61'(mul_r[k].vs) * 61'(MS);
      rcp_nxt[k].pc = 61'(mul_r[k].vc) * 61'(MC);
    end

    // quotient correction and accumulate
    always_comb begin
      logic [30:0] qs0, rs, qs;
      logic [30:0] qc0, rc, qc;
      qs0 = rcp_r[k].ps[60:30];
      rs  = rcp_r[k].vs - 31'(qs0 * DSV);
      qs  = qs0 + 31'(rs >= DSV);
      qc0 = rcp_r[k].pc[60:30];
      rc  = rcp_r[k].vc - 31'(qc0 * DCV);
      qc  = qc0 + 31'(rc >= DCV);
      st_nxt[k] = rcp_r[k].st;
      if (k <= 5) begin
        st_nxt[k].ts = qs;
        if ((k & 1) == 1) begin
          st_nxt[k].ss = rcp_r[k].st.ss - $signed({1'b0, qs});
        end else begin
          st_nxt[k].ss = rcp_r[k].st.ss + $signed({1'b0, qs});
        end
      end
      st_nxt[k].tc = qc;
      if ((k & 1) == 1) begin
        st_nxt[k].cc = rcp_r[k].st.cc - $signed({1'b0, qc});
      end else begin
        st_nxt[k].cc = rcp_r[k].st.cc + $signed({1'b0, qc});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mul_r[k] <= mul_nxt[k];
        rcp_r[k] <= rcp_nxt[k];
        st_r[k]  <= st_nxt[k];
      end
    end
  end

  // round to trig format, undo the octant fold and the quadrant
  always_comb begin
    evz_pkg::trig_t sv, cv, s0, c0;
    sv = $signed({1'b0, to_trig(st_r[6].ss)});
    cv = $signed({1'b0, to_trig(st_r[6].cc)});
    if (st_r[6].meta.swap) begin
      s0 = cv;
      c0 = sv;
    end else begin
      s0 = sv;
      c0 = cv;
    end
    case (st_r[6].meta.quad)
      QUAD_0: begin
        trig_nxt.sn = s0;
        trig_nxt.cs = c0;
      end
      QUAD_1: begin
        trig_nxt.sn = c0;
        trig_nxt.cs = -s0;
      end
      QUAD_2: begin
        trig_nxt.sn = -s0;
        trig_nxt.cs = -c0;
      end
      default: begin
        trig_nxt.sn = -c0;
        trig_nxt.cs = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r      <= r_nxt;
      m2_r     <= m2_nxt;
      g_r      <= g_nxt;
      xa_r     <= xa_nxt;
      xb_r     <= xb_nxt;
      xc_r     <= xc_nxt;
      st_r[0]  <= st_nxt[0];
      trig_r   <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

/* sv/evz_merge.sv */
`timescale 1ns / 1ps
// Merge stage: builds the ZXZ matrix from the three lanes and applies it
// to the point with rounding and saturation. Depends on evz_pkg.
module evz_merge (
  input  logic                clk,
  input  logic                en,
  input  evz_pkg::trig_pair_t phi,
  input  evz_pkg::trig_pair_t the,
  input  evz_pkg::trig_pair_t psi,
  input  evz_pkg::vec_t       pt,
  output evz_pkg::vec_t       res
);

  localparam int TW     = evz_pkg::TRIG_W;
  localparam int MW     = evz_pkg::MAT_W;
  localparam int PROD_W = MW + evz_pkg::COORD_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int FB     = evz_pkg::TRIG_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

  typedef logic signed [MW-1:0]     mat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    evz_pkg::trig_t ts, tc, pcc, pcs, psc, pss, a13, a23, a31, p32, cthe, spsi, cpsi;
  } m1_t;

  typedef struct packed {
    mat_t a11, a12, a13, a21, a22, a23, a31, a32, a33;
  } m2_t;

  typedef struct packed {
    prod_t p11, p12, p13, p21, p22, p23, p31, p32, p33;
  } m3_t;

  typedef struct packed {
    acc_t x, y, z;
  } acc3_t;

  // trig product rounded half away from zero
  function automatic evz_pkg::trig_t tmul(input evz_pkg::trig_t a, input evz_pkg::trig_t b);
    logic signed [2*TW-1:0] p;
    logic [2*TW-1:0]        mag;
    logic [2*TW-1:0]        r;
    p   = a * b;
    mag = (p < 0) ? (2*TW)'(-p) : (2*TW)'(p);
    r   = (mag + ((2*TW)'(1) << (FB - 1))) >> FB;
    return (p < 0) ? -$signed(r[TW-1:0]) : $signed(r[TW-1:0]);
  endfunction

  // accumulator rounded half away from zero
  function automatic acc_t rnd_acc(input acc_t v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = (v < 0) ? ACC_W'(-v) : ACC_W'(v);
    r   = (mag + (ACC_W'(1) << (FB - 1))) >> FB;
    return (v < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic evz_pkg::coord_t sat32(input acc_t v);
    if (v > SAT_HI) begin
      return evz_pkg::COORD_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return evz_pkg::COORD_W'(SAT_LO);
    end
    return v[evz_pkg::COORD_W-1:0];
  endfunction

  m1_t   m1_r, m1_nxt;
  m2_t   m2_r, m2_nxt;
  m3_t   m3_r, m3_nxt;
  acc3_t m4_r, m4_nxt;
  acc3_t m5_r, m5_nxt;

  // first-level products of the angle terms
  always_comb begin
    m1_nxt.ts   = tmul(the.cs, phi.sn);
    m1_nxt.tc   = tmul(the.cs, phi.cs);
    m1_nxt.pcc  = tmul(psi.cs, phi.cs);
    m1_nxt.pcs  = tmul(psi.cs, phi.sn);
    m1_nxt.psc  = tmul(psi.sn, phi.cs);
    m1_nxt.pss  = tmul(psi.sn, phi.sn);
    m1_nxt.a13  = tmul(psi.sn, the.sn);
    m1_nxt.a23  = tmul(psi.cs, the.sn);
    m1_nxt.a31  = tmul(the.sn, phi.sn);
    m1_nxt.p32  = tmul(the.sn, phi.cs);
    m1_nxt.cthe = the.cs;
    m1_nxt.spsi = psi.sn;
    m1_nxt.cpsi = psi.cs;
  end

  // matrix entries
  always_comb begin
    m2_nxt.a11 = MW'(m1_r.pcc) - MW'(tmul(m1_r.ts, m1_r.spsi));
    m2_nxt.a12 = MW'(m1_r.pcs) + MW'(tmul(m1_r.tc, m1_r.spsi));
    m2_nxt.a13 = MW'(m1_r.a13);
    m2_nxt.a21 = -MW'(m1_r.psc) - MW'(tmul(m1_r.ts, m1_r.cpsi));
    m2_nxt.a22 = -MW'(m1_r.pss) + MW'(tmul(m1_r.tc, m1_r.cpsi));
    m2_nxt.a23 = MW'(m1_r.a23);
    m2_nxt.a31 = MW'(m1_r.a31);
    m2_nxt.a32 = -MW'(m1_r.p32);
    m2_nxt.a33 = MW'(m1_r.cthe);
  end

  // matrix times point
  always_comb begin
    m3_nxt.p11 = PROD_W'(m2_r.a11) * PROD_W'(pt.x);
    m3_nxt.p12 = PROD_W'(m2_r.a12) * PROD_W'(pt.y);
    m3_nxt.p13 = PROD_W'(m2_r.a13) * PROD_W'(pt.z);
    m3_nxt.p21 = PROD_W'(m2_r.a21) * PROD_W'(pt.x);
    m3_nxt.p22 = PROD_W'(m2_r.a22) * PROD_W'(pt.y);
    m3_nxt.p23 = PROD_W'(m2_r.a23) * PROD_W'(pt.z);
    m3_nxt.p31 = PROD_W'(m2_r.a31) * PROD_W'(pt.x);
    m3_nxt.p32 = PROD_W'(m2_r.a32) * PROD_W'(pt.y);
    m3_nxt.p33 = PROD_W'(m2_r.a33) * PROD_W'(pt.z);
  end

  // row sums
  always_comb begin
    m4_nxt.x = ACC_W'(m3_r.p11) + ACC_W'(m3_r.p12) + ACC_W'(m3_r.p13);
    m4_nxt.y = ACC_W'(m3_r.p21) + ACC_W'(m3_r.p22) + ACC_W'(m3_r.p23);
    m4_nxt.z = ACC_W'(m3_r.p31) + ACC_W'(m3_r.p32) + ACC_W'(m3_r.p33);
  end

  // back to coordinate scale
  always_comb begin
    m5_nxt.x = rnd_acc(m4_r.x);
    m5_nxt.y = rnd_acc(m4_r.y);
    m5_nxt.z = rnd_acc(m4_r.z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      m4_r <= m4_nxt;
      m5_r <= m5_nxt;
    end
  end

  // saturate to 32 bits
  assign res.x = sat32(m5_r.x);
  assign res.y = sat32(m5_r.y);
  assign res.z = sat32(m5_r.z);

endmodule

/* sv/euler_zxz_vector_rotation_core.sv */
`timescale 1ns / 1ps
// ZXZ Euler-angle rotation of a 3D point, fully pipelined.
// Depends on evz_pkg, evz_in_if, evz_out_if, evz_trig_lane and evz_merge.
//
// Requests arrive on in_if: a Q15.16 point and three angles in 1/64 degree.
// Each result on out_if is the point rotated by Rz(psi) * Rx(theta) * Rz(phi),
// rounded and saturated to 32 bits; results leave in request order.
// Three trig lanes, one per angle, run side by side (25 stages each) and the
// merge stage forms the matrix and the product (5 stages).
// A request passes through the 30 pipeline stages and then the output
// buffer on its way to out_if.valid.
// Throughput: one request per cycle while out_if.ready stays high; the
// pipeline has no feedback, so the rate is set by nothing but the
// two-entry output buffer.
// Stall: when the receiver holds ready low the output buffer fills; once it
// holds two results the whole pipeline freezes and in_if.ready is low. One
// waiting result still lets new requests enter.
// Reset: synchronous, active low; clears in-flight valid flags and the buffer.
module euler_zxz_vector_rotation_core (
  input  logic       clk,
  input  logic       rst_n,
  evz_in_if.sink     in_if,
  evz_out_if.source  out_if
);

  localparam int OBUF_DEPTH = 2;

  logic                        en;
  logic                        push;
  logic                        pop;
  logic [evz_pkg::PIPE_LAT-1:0] vld_r;
  evz_pkg::vec_t               pt_r [0:evz_pkg::PT_LAT-1];
  evz_pkg::trig_pair_t         t_phi, t_the, t_psi;
  evz_pkg::vec_t               res;
  evz_pkg::vec_t               buf_r [0:OBUF_DEPTH-1];
  logic                        wr_ptr_r, rd_ptr_r;
  logic [1:0]                  cnt_r, cnt_nxt;

  // pipeline advances unless the output buffer is full
  assign en          = (cnt_r != 2'(OBUF_DEPTH));
  assign in_if.ready = en;
  assign push        = en && vld_r[evz_pkg::PIPE_LAT-1];
  assign pop         = (cnt_r != 2'd0) && out_if.ready;

  // valid flags along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[evz_pkg::PIPE_LAT-2:0], in_if.valid};
    end
  end

  // point delay line up to the matrix product
  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0] <= {in_if.px, in_if.py, in_if.pz};
      for (int i = 1; i < evz_pkg::PT_LAT; i++) begin
        pt_r[i] <= pt_r[i-1];
      end
    end
  end

  evz_trig_lane u_lane_phi (.clk(clk), .en(en), .angle(in_if.angle_phi),   .trig(t_phi));
  evz_trig_lane u_lane_the (.clk(clk), .en(en), .angle(in_if.angle_theta), .trig(t_the));
  evz_trig_lane u_lane_psi (.clk(clk), .en(en), .angle(in_if.angle_psi),   .trig(t_psi));

  evz_merge u_merge (
    .clk (clk),
    .en  (en),
    .phi (t_phi),
    .the (t_the),
    .psi (t_psi),
    .pt  (pt_r[evz_pkg::PT_LAT-1]),
    .res (res)
  );

  // output buffer count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_if.valid = (cnt_r != 2'd0);
  assign out_if.rx    = buf_r[rd_ptr_r].x;
  assign out_if.ry    = buf_r[rd_ptr_r].y;
  assign out_if.rz    = buf_r[rd_ptr_r].z;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the ZXZ Euler rotation core: random and corner
// points and angles, with a predictor of the fixed-point rotation. Depends on evz_pkg,
// evz_in_if, evz_out_if and euler_zxz_vector_rotation_core.
module tb;

  typedef evz_pkg::coord_t coord_t;
  typedef evz_pkg::angle_t angle_t;

  localparam int TFB      = 15;
  localparam int N_RANDOM = 600;
  localparam logic [63:0] PI_Q48_C = 64'h3_243F_6A88_85A3;
  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    angle_t phi;
    angle_t theta;
    angle_t psi;
  } rot_req_t;

  typedef struct packed {
    coord_t rx;
    coord_t ry;
    coord_t rz;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  evz_in_if  in_if ();
  evz_out_if out_if ();

  euler_zxz_vector_rotation_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk = ~clk;

  rot_req_t pending_reqs[$];
  rot_res_t expected_points[$];
  int       n_mismatch = 0;
  int       n_unexpected = 0;
  int       n_checked = 0;
  bit       stim_done = 1'b0;

  // rounded right shift, half away from zero
  function automatic longint round_shift(input longint v, input int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v < 0) return -((-v + half) >>> n);
    return (v + half) >>> n;
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint clamp_trig(input longint v);
    if (v < 0) v = 0;
    if (v > longint'(Q30_ONE)) v = longint'(Q30_ONE);
    return round_shift(v, 30 - TFB);
  endfunction

  // series sine and cosine over one octant, angle g in 1/64 degree
  task automatic octant_sin_cos(input int g, output longint sn, output longint cs);
    logic [63:0] x, x2, t;
    longint s, c;
    x = ((64'(g) * PI_Q48_C) / 64'd11520 + (64'd1 << 17)) >> 18;
    x2 = q30_mul(x, x);
    t = x;
    s = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      t = q30_mul(t, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2) s -= longint'(t);
      else s += longint'(t);
    end
    t = Q30_ONE;
    c = longint'(t);
    for (int k = 1; k <= 6; k++) begin
      t = q30_mul(t, x2) / 64'((2 * k - 1) * (2 * k));
      if (k % 2) c -= longint'(t);
      else c += longint'(t);
    end
    sn = clamp_trig(s);
    cs = clamp_trig(c);
  endtask

  task automatic angle_sin_cos(input angle_t a, output longint sn, output longint cs);
    int r, q, f;
    longint s0, c0;
    r = int'(a) % 23040;
    if (r < 0) r += 23040;
    q = r / 5760;
    f = r % 5760;
    if (f > 2880) octant_sin_cos(5760 - f, c0, s0);
    else octant_sin_cos(f, s0, c0);
    case (q)
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endtask

  function automatic longint trig_mul(input longint a, input longint b);
    return round_shift(a * b, TFB);
  endfunction

  function automatic coord_t saturate_coord(input longint acc);
    longint v;
    v = round_shift(acc, TFB);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return coord_t'(v);
  endfunction

  // expected rotated point for one request
  task automatic predict_rotation(input rot_req_t r, output rot_res_t p);
    longint sphi, cphi, sthe, cthe, spsi, cpsi, ts, tc;
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, x, y, z;
    angle_sin_cos(r.phi, sphi, cphi);
    angle_sin_cos(r.theta, sthe, cthe);
    angle_sin_cos(r.psi, spsi, cpsi);
    x = longint'(r.px);
    y = longint'(r.py);
    z = longint'(r.pz);
    ts = trig_mul(cthe, sphi);
    tc = trig_mul(cthe, cphi);
    a11 = trig_mul(cpsi, cphi) - trig_mul(ts, spsi);
    a12 = trig_mul(cpsi, sphi) + trig_mul(tc, spsi);
    a13 = trig_mul(spsi, sthe);
    a21 = -trig_mul(spsi, cphi) - trig_mul(ts, cpsi);
    a22 = -trig_mul(spsi, sphi) + trig_mul(tc, cpsi);
    a23 = trig_mul(cpsi, sthe);
    a31 = trig_mul(sthe, sphi);
    a32 = -trig_mul(sthe, cphi);
    a33 = cthe;
    p.rx = saturate_coord(a11 * x + a12 * y + a13 * z);
    p.ry = saturate_coord(a21 * x + a22 * y + a23 * z);
    p.rz = saturate_coord(a31 * x + a32 * y + a33 * z);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return coord_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 7))
      0: return angle_t'($urandom);
      1: return angle_t'(5760 * $signed($urandom_range(0, 8)) - 23040);
      2: return angle_t'(2880 + $signed($urandom_range(0, 2)) - 1);
      default: return angle_t'($signed($urandom_range(0, 46079)) - 23040);
    endcase
  endfunction

  // driver: one request per accepted handshake, random gaps
  int drv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid       <= 1'b0;
      in_if.px          <= '0;
      in_if.py          <= '0;
      in_if.pz          <= '0;
      in_if.angle_phi   <= '0;
      in_if.angle_theta <= '0;
      in_if.angle_psi   <= '0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      in_if.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      rot_req_t r;
      rot_res_t p;
      r = pending_reqs.pop_front();
      predict_rotation(r, p);
      expected_points.push_back(p);
      in_if.valid       <= 1'b1;
      in_if.px          <= r.px;
      in_if.py          <= r.py;
      in_if.pz          <= r.pz;
      in_if.angle_phi   <= r.phi;
      in_if.angle_theta <= r.theta;
      in_if.angle_psi   <= r.psi;
      drv_gap <= gap_len();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver stall pattern
  int rdy_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rdy_cnt > 0) begin
      rdy_cnt <= rdy_cnt - 1;
    end else begin
      out_if.ready <= ~out_if.ready;
      rdy_cnt <= out_if.ready ? gap_len() : $urandom_range(0, 12);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      rot_res_t e;
      if (expected_points.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= 10)
          $display("unexpected result %h %h %h", out_if.rx, out_if.ry, out_if.rz);
      end else begin
        e = expected_points.pop_front();
        n_checked++;
        if (e.rx !== out_if.rx || e.ry !== out_if.ry || e.rz !== out_if.rz) begin
          n_mismatch++;
          if (n_mismatch + n_unexpected <= 10)
            $display("mismatch #%0d: exp %h %h %h got %h %h %h", n_checked,
                     e.rx, e.ry, e.rz, out_if.rx, out_if.ry, out_if.rz);
        end
      end
    end
  end

  initial begin
    rot_req_t r;

    // directed: zero angles, angle extremes, octant boundaries, saturation
    pending_reqs.push_back('{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0});
    pending_reqs.push_back('{32'sh0001_0000, 0, 0, 16'sd5760, 0, 0});
    pending_reqs.push_back('{0, 32'sh0001_0000, 0, 0, 16'sd5760, 0});
    pending_reqs.push_back('{32'sh0001_0000, 0, 0, 0, 0, 16'sd5760});
    pending_reqs.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             16'sd2880, 16'sd2880, 16'sd2880});
    pending_reqs.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             16'sd2880, 16'sd2880, 16'sd2880});
    pending_reqs.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             -16'sd23040, 16'sd23039, -16'sd23040});
    pending_reqs.push_back('{32'sh0100_0000, 32'shFF00_0000, 32'sh0000_8000,
                             16'sd2881, 16'sd2879, 16'sd11520});
    pending_reqs.push_back('{32'shFFFF_FFFF, 32'sh0000_0001, 32'sh1234_5678,
                             16'sh7FFF, 16'sh8000, 16'shFFFF});
    pending_reqs.push_back('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                             16'sd17280, -16'sd5760, -16'sd11520});
    pending_reqs.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                             16'sd1000, 16'sd3000, 0});
    for (int i = 0; i < N_RANDOM; i++) begin
      r.px = rand_coord();
      r.py = rand_coord();
      r.pz = rand_coord();
      r.phi = rand_angle();
      r.theta = rand_angle();
      r.psi = ($urandom_range(0, 5) == 0) ? angle_t'(0) : rand_angle();
      pending_reqs.push_back(r);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && expected_points.size() == 0);
    repeat (60) @(posedge clk);
    $display("checked %0d rotated points over corner and random angles and coordinates",
             n_checked);
    $display("mismatches %0d, unexpected results %0d", n_mismatch, n_unexpected);
    if (n_mismatch == 0 && n_unexpected == 0 && expected_points.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_points.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
